// ===== hdl/sebc_pkg.sv =====
// shared widths, register indexes and constants for the skeleton endpoint counter
package sebc_pkg;

	localparam int unsigned PIXEL_W = 8;
	localparam int unsigned COUNT_W = 20;
	localparam int unsigned DIM_W = 11;
	localparam int unsigned APB_DATA_W = 32;

	localparam int unsigned DEFAULT_MAX_WIDTH = 1024;
	localparam int unsigned DEFAULT_MAX_HEIGHT = 1024;

	// register index as seen on paddr[2]
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [3:0] ENDPOINT_NEIGHBOURS = 4'd1;
	localparam logic [3:0] BRANCH_NEIGHBOURS = 4'd3;
	localparam logic [8:0] NEIGHBOUR_MASK = 9'h1EF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// ===== hdl/sebc_if.sv =====
// valid/ready channels for skeleton pixels and frame counts
interface sebc_pixel_if;
	logic valid;
	logic ready;
	logic [sebc_pkg::PIXEL_W-1:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

interface sebc_count_if;
	logic valid;
	logic ready;
	logic [sebc_pkg::COUNT_W-1:0] endpoint_count;
	logic [sebc_pkg::COUNT_W-1:0] branchpoint_count;

	modport source(output valid, output endpoint_count, output branchpoint_count, input ready);
	modport sink(input valid, input endpoint_count, input branchpoint_count, output ready);
endinterface

// ===== hdl/skeleton_endpoint_branch_counter_core.sv =====
// skeleton endpoint / branchpoint counter: line memory, 3x3 window, frame counts
//
// Takes a skeleton frame one pixel word per clock in raster order (any nonzero
// byte is a set pixel) and, on the last pixel of the frame, delivers one word
// with the number of interior set pixels that have exactly one set 8-connected
// neighbour (endpoints) and the number that have three or more (branchpoints).
// Border pixels are never counted, and frames narrower or shorter than three
// pixels report zero. The two previous rows live in one line memory of
// MAX_WIDTH entries by two bits with a registered read port; each pixel reads
// its column, shifts the column into the 3x3 window and writes the column back
// one row down. Throughput is one pixel per clock while the input is not
// stalled: the memory is read in the accept cycle and written as the pixel
// leaves stage 1; a write colliding with the following read of the same column
// (one-pixel-wide frames) is forwarded. Stage 2 loads the count word. The input
// stalls only when a frame result is ready while the previous count word has
// not been taken yet. The line memory needs no clearing pass after reset:
// every column is rewritten during the first two rows of a frame before any
// pixel is evaluated. Registers: image_width at byte address 0, image_height
// at byte address 4, 11 bits each; a zero acts as one and a value above the
// maximum acts as the maximum. A register write restarts the frame and
// clears both counts; write only while the block is idle.
module skeleton_endpoint_branch_counter_core #(
	parameter int unsigned MAX_WIDTH = sebc_pkg::DEFAULT_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = sebc_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,

	sebc_pixel_if.sink pixels,
	sebc_count_if.source counts,

	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:2] paddr,
	input  logic [sebc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sebc_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned DW = sebc_pkg::DIM_W;
	localparam int unsigned NW = sebc_pkg::COUNT_W;

	// stage 1: word accepted, line memory read in flight
	typedef struct packed {
		logic          cur;
		logic [CW-1:0] col;
		logic          interior;
		logic          last;
	} s1_t;

	// stage 2: pixel classified, counts updated here
	typedef struct packed {
		logic is_end;
		logic is_branch;
		logic last;
	} s2_t;

	// last valid index for a raw register value, after clamping to 1..maxv
	function automatic logic [31:0] last_index(input logic [DW-1:0] v,
			input int unsigned maxv);
		logic [31:0] ext;
		ext = 32'(v);
		if (v == '0) begin
			return 32'd0;
		end else if (ext > maxv) begin
			return maxv - 1;
		end else begin
			return ext - 32'd1;
		end
	endfunction

	function automatic logic [3:0] pop9(input logic [8:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 9; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	// configuration
	logic [DW-1:0] width_q, height_q;
	logic [CW-1:0] col_last_q;
	logic [RW-1:0] row_last_q;
	logic          cfg_wr;

	// position in the frame
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// pipeline
	logic advance, accept, mem_wr;
	logic s1_valid_s1, s2_valid_s2;
	s1_t  s1_s1;
	s2_t  s2_s2;

	// line memory: bit 1 row above, bit 0 two rows above
	logic [1:0] line_mem [MAX_WIDTH];
	logic [1:0] rd_q, fwd_data_q, rd_data, wr_data;
	logic       fwd_q;

	logic [8:0] win_q, win_new;
	logic [3:0] nb;
	logic       centre;

	logic [NW-1:0] ends_q, branches_q, ends_next, branches_next;
	logic          out_valid_q;
	logic [NW-1:0] out_ends_q, out_branches_q;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr)
			sebc_pkg::REG_IMAGE_WIDTH:  prdata = sebc_pkg::APB_DATA_W'(width_q);
			sebc_pkg::REG_IMAGE_HEIGHT: prdata = sebc_pkg::APB_DATA_W'(height_q);
			default:                    prdata = '0;
		endcase
	end

	// handshake: stall only when a frame result meets a full output register that is not being taken
	assign advance = !(s2_valid_s2 && s2_s2.last && out_valid_q && !counts.ready);
	assign pixels.ready = advance;
	assign accept = pixels.valid && advance;
	assign mem_wr = s1_valid_s1 && advance;

	// read-modify-write of the column, with forwarding of a same-column write
	assign rd_data = fwd_q ? fwd_data_q : rd_q;
	assign wr_data = {s1_s1.cur, rd_data[1]};

	// newest column in the low bits: bit 0 top, bit 1 middle, bit 2 bottom
	assign win_new = {win_q[5:0], s1_s1.cur, rd_data[1], rd_data[0]};
	assign centre = win_new[4];
	assign nb = pop9(win_new & sebc_pkg::NEIGHBOUR_MASK);

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			line_mem[s1_s1.col] <= wr_data;
		end
		if (accept) begin
			rd_q <= line_mem[col_q];
			fwd_data_q <= wr_data;
		end
	end

	// saturating counts including the pixel in stage 2
	always_comb begin
		ends_next = ends_q;
		branches_next = branches_q;
		if (s2_s2.is_end && ends_q != sebc_pkg::COUNT_MAX) begin
			ends_next = ends_q + NW'(1);
		end
		if (s2_s2.is_branch && branches_q != sebc_pkg::COUNT_MAX) begin
			branches_next = branches_q + NW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DW'(MAX_WIDTH);
			height_q <= DW'(MAX_HEIGHT);
			col_last_q <= CW'(MAX_WIDTH - 1);
			row_last_q <= RW'(MAX_HEIGHT - 1);
			col_q <= '0;
			row_q <= '0;
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
			fwd_q <= 1'b0;
			win_q <= '0;
			ends_q <= '0;
			branches_q <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_wr) begin
			// any register write restarts the frame
			case (paddr)
				sebc_pkg::REG_IMAGE_WIDTH: begin
					width_q <= pwdata[DW-1:0];
					col_last_q <= CW'(last_index(pwdata[DW-1:0], MAX_WIDTH));
				end
				sebc_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[DW-1:0];
					row_last_q <= RW'(last_index(pwdata[DW-1:0], MAX_HEIGHT));
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
			ends_q <= '0;
			branches_q <= '0;
		end else begin
			// word taken and no new frame result loading behind it
			if (counts.ready && !(s2_valid_s2 && advance && s2_s2.last)) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				s1_valid_s1 <= accept;
				s2_valid_s2 <= s1_valid_s1;
			end
			if (accept) begin
				fwd_q <= s1_valid_s1 && (s1_s1.col == col_q);
				if (col_q == col_last_q && row_q == row_last_q) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_q == col_last_q) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (mem_wr) begin
				win_q <= win_new;
			end
			if (s2_valid_s2 && advance) begin
				if (s2_s2.last) begin
					out_valid_q <= 1'b1;
					ends_q <= '0;
					branches_q <= '0;
				end else begin
					ends_q <= ends_next;
					branches_q <= branches_next;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1.cur <= (pixels.pixel != '0);
			s1_s1.col <= col_q;
			s1_s1.interior <= (col_q >= CW'(2)) && (row_q >= RW'(2));
			s1_s1.last <= (col_q == col_last_q) && (row_q == row_last_q);
		end
		if (mem_wr) begin
			s2_s2.is_end <= s1_s1.interior && centre && (nb == sebc_pkg::ENDPOINT_NEIGHBOURS);
			s2_s2.is_branch <= s1_s1.interior && centre && (nb >= sebc_pkg::BRANCH_NEIGHBOURS);
			s2_s2.last <= s1_s1.last;
		end
		if (s2_valid_s2 && advance && s2_s2.last) begin
			out_ends_q <= ends_next;
			out_branches_q <= branches_next;
		end
	end

	assign counts.valid = out_valid_q;
	assign counts.endpoint_count = out_ends_q;
	assign counts.branchpoint_count = out_branches_q;

	// a count word only appears after the last pixel of a frame left stage 2
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_valid_s2 && s2_s2.last))
		else $error("count word without a frame end");

	// the input only stalls on a frame result blocked by a waiting word
	assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> (counts.valid && !counts.ready && s2_valid_s2 && s2_s2.last))
		else $error("input stalled without a blocked result");

	// the position never runs past the configured frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= col_last_q) && (row_q <= row_last_q))
		else $error("frame position out of range");

endmodule
